[hw/rtl/cbt_pkg.sv]
// Shared types, widths and constants of the cubic Bezier tessellator.
// Holds the Bernstein weight table, which is built at elaboration time.
// No dependencies.
package cbt_pkg;

   localparam int SEGMENTS = 32;
   localparam int SEG_LAST = SEGMENTS - 1;
   localparam int IDX_W = $clog2(SEGMENTS);

   localparam int COORD_W = 16;
   localparam int WEIGHT_W = 17;
   localparam int TERM_W = COORD_W + WEIGHT_W + 1;
   localparam int SUM_W = TERM_W + 2;
   localparam int SIZE_W = 12;
   localparam int SCALED_W = SUM_W + SIZE_W + 1;
   localparam int PIX_SHIFT = 26;
   localparam int SHIFTED_W = SCALED_W - PIX_SHIFT;
   localparam int PIX_W = 18;
   localparam int VIDX_W = 5;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam int CSR_IDX_W = 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FRAME_WIDTH  = 2'd0,
      CSR_FRAME_HEIGHT = 2'd1
   } csr_index_type;

   // Packed so that start_x lands in the lowest bits of the stream word.
   typedef struct packed {
      logic signed [COORD_W-1:0] end_y;
      logic signed [COORD_W-1:0] end_x;
      logic signed [COORD_W-1:0] pull_b_y;
      logic signed [COORD_W-1:0] pull_b_x;
      logic signed [COORD_W-1:0] pull_a_y;
      logic signed [COORD_W-1:0] pull_a_x;
      logic signed [COORD_W-1:0] start_y;
      logic signed [COORD_W-1:0] start_x;
   } curve_type;

   typedef struct packed {
      logic      valid;
      curve_type curve;
   } head_type;

   typedef logic [3:0][WEIGHT_W-1:0] weight_set_type;
   typedef weight_set_type [SEGMENTS-1:0] weight_table_type;

   localparam longint unsigned WEIGHT_DEN = longint'(SEG_LAST) * SEG_LAST * SEG_LAST;
   localparam longint unsigned WEIGHT_DEN2 = 2 * WEIGHT_DEN;
   localparam longint unsigned WEIGHT_ONE2 = 2 * 65536;

   // Each weight is the exact rational value rounded to nearest, ties up, in Q1.16.
   function automatic weight_table_type build_weight_table();
      weight_table_type tbl;
      longint unsigned  iv;
      longint unsigned  jv;
      for (int i = 0; i < SEGMENTS; i++) begin
         iv = longint'(i);
         jv = longint'(SEG_LAST) - iv;
         tbl[i][0] = WEIGHT_W'((jv * jv * jv * WEIGHT_ONE2 + WEIGHT_DEN) / WEIGHT_DEN2);
         tbl[i][1] = WEIGHT_W'((3 * jv * jv * iv * WEIGHT_ONE2 + WEIGHT_DEN) / WEIGHT_DEN2);
         tbl[i][2] = WEIGHT_W'((3 * jv * iv * iv * WEIGHT_ONE2 + WEIGHT_DEN) / WEIGHT_DEN2);
         tbl[i][3] = WEIGHT_W'((iv * iv * iv * WEIGHT_ONE2 + WEIGHT_DEN) / WEIGHT_DEN2);
      end
      return tbl;
   endfunction

   localparam weight_table_type WEIGHT_TABLE = build_weight_table();

endpackage

[hw/rtl/cubic_bezier_tessellator_unit.sv]
// Cubic Bezier tessellator top level: stream ports, frame size registers,
// curve queue and vertex evaluator. Depends on cbt_pkg, cbt_queue, cbt_eval.
//
// Usage:
//   req_*  : one item per curve, four control points in signed Q2.14.
//   rsp_*  : SEGMENTS vertices per curve, x and y as signed pixels with four
//            fraction bits, the position along the curve, and tlast on the
//            final vertex.
//   csr_*  : register writes; index 0 sets the frame width, index 1 the frame
//            height. Writes are always taken; other indexes are dropped.
// A curve accepted into an empty block is stored in the queue, and its first
// vertex then passes the evaluation pipeline registers. Throughput: one vertex
// per cycle unless rsp_tready stalls the output; each curve passes SEGMENTS
// vertices through the single evaluation pipeline. A two-entry curve queue in
// front keeps the next curve ready, so consecutive curves run without a gap.
// Reset clears the frame size registers to zero and empties the queue and
// the pipeline. While a vertex waits at the output with rsp_tready low, the
// whole pipeline holds still and new curves are taken only while the queue
// has room.
module cubic_bezier_tessellator_unit (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // start_x, start_y, pull_a_x, pull_a_y, pull_b_x, pull_b_y, end_x, end_y
   input  logic [127:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // vertex_x [17:0], vertex_y [35:18], vertex_index [40:36], zeros [47:41]
   output logic [47:0]  rsp_tdata,
   output logic         rsp_tlast,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [cbt_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [cbt_pkg::SIZE_W-1:0]    csr_data
);

   logic [cbt_pkg::SIZE_W-1:0] frame_width_ff, frame_width_in;
   logic [cbt_pkg::SIZE_W-1:0] frame_height_ff, frame_height_in;
   logic              q_not_full;
   logic              q_pop;
   cbt_pkg::head_type q_head;
   logic signed [cbt_pkg::PIX_W-1:0] vx, vy;
   logic [cbt_pkg::VIDX_W-1:0] vidx;

   assign csr_ready = 1'b1;

   always_comb begin
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      if (csr_valid) begin
         case (csr_index)
            cbt_pkg::CSR_FRAME_WIDTH:  frame_width_in  = csr_data;
            cbt_pkg::CSR_FRAME_HEIGHT: frame_height_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= '0;
         frame_height_ff <= '0;
      end else begin
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
      end
   end

   assign req_tready = q_not_full;

   cbt_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (req_tvalid && q_not_full),
      .push_curve (cbt_pkg::curve_type'(req_tdata)),
      .not_full   (q_not_full),
      .pop        (q_pop),
      .head       (q_head)
   );

   cbt_eval u_eval (
      .clock        (clock),
      .reset        (reset),
      .head         (q_head),
      .pop          (q_pop),
      .frame_width  (frame_width_ff),
      .frame_height (frame_height_ff),
      .out_valid    (rsp_tvalid),
      .out_ready    (rsp_tready),
      .out_x        (vx),
      .out_y        (vy),
      .out_index    (vidx),
      .out_last     (rsp_tlast)
   );

   assign rsp_tdata = {7'd0, vidx, vy, vx};

endmodule

[hw/rtl/cbt_queue.sv]
// Short queue of accepted curves between the input side and the evaluator.
// Depends on cbt_pkg.
module cbt_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  cbt_pkg::curve_type push_curve,
   output logic              not_full,
   input  logic              pop,
   output cbt_pkg::head_type head
);

   cbt_pkg::curve_type mem_ff [cbt_pkg::QUEUE_DEPTH];
   logic [cbt_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [cbt_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [cbt_pkg::QCNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == cbt_pkg::QPTR_W'(cbt_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == cbt_pkg::QPTR_W'(cbt_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_curve;
      end
   end

   assign not_full   = (count_ff != cbt_pkg::QCNT_W'(cbt_pkg::QUEUE_DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.curve = mem_ff[rd_ptr_ff];

   a_pop_needs_entry : assert property (@(posedge clock) disable iff (reset)
      pop |-> head.valid)
      else $error("queue popped while empty");

   a_count_bounded : assert property (@(posedge clock) disable iff (reset)
      count_ff <= cbt_pkg::QCNT_W'(cbt_pkg::QUEUE_DEPTH))
      else $error("queue count beyond depth");

   a_push_tracks_count : assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count missed a push");

endmodule

[hw/rtl/cbt_eval.sv]
// Vertex evaluator: steps through the vertices of the curve at the queue head
// and runs each through a five-stage weight, sum, scale and clamp pipeline.
// Depends on cbt_pkg.
module cbt_eval (
   input  logic                         clock,
   input  logic                         reset,
   input  cbt_pkg::head_type            head,
   output logic                         pop,
   input  logic [cbt_pkg::SIZE_W-1:0]   frame_width,
   input  logic [cbt_pkg::SIZE_W-1:0]   frame_height,
   output logic                         out_valid,
   input  logic                         out_ready,
   output logic signed [cbt_pkg::PIX_W-1:0] out_x,
   output logic signed [cbt_pkg::PIX_W-1:0] out_y,
   output logic [cbt_pkg::VIDX_W-1:0]   out_index,
   output logic                         out_last
);

   localparam logic signed [cbt_pkg::SHIFTED_W-1:0] PIX_MAX =
      cbt_pkg::SHIFTED_W'((64'sd1 <<< (cbt_pkg::PIX_W - 1)) - 1);
   localparam logic signed [cbt_pkg::SHIFTED_W-1:0] PIX_MIN =
      cbt_pkg::SHIFTED_W'(-(64'sd1 <<< (cbt_pkg::PIX_W - 1)));

   logic advance;
   logic issue;
   logic [cbt_pkg::IDX_W-1:0] cnt_ff, cnt_in;

   // Stage valid bits, and index and last flag carried alongside the data.
   logic [5:1] valid_ff, valid_in;
   logic [cbt_pkg::IDX_W-1:0] idx_ff [1:5];
   logic [5:1] last_ff;

   cbt_pkg::weight_set_type s1_w_ff;
   logic signed [cbt_pkg::COORD_W-1:0] s1_px_ff [4];
   logic signed [cbt_pkg::COORD_W-1:0] s1_py_ff [4];
   logic signed [cbt_pkg::TERM_W-1:0] s2_tx_ff [4];
   logic signed [cbt_pkg::TERM_W-1:0] s2_ty_ff [4];
   logic signed [cbt_pkg::SUM_W-1:0] s3_sx_ff, s3_sy_ff;
   logic signed [cbt_pkg::SCALED_W-1:0] s4_x_ff, s4_y_ff;
   logic signed [cbt_pkg::SHIFTED_W-1:0] sh_x, sh_y;
   logic signed [cbt_pkg::PIX_W-1:0] s5_x_ff, s5_y_ff, s5_x_in, s5_y_in;

   // The whole pipeline moves as one while the output register can take a vertex.
   assign advance = !valid_ff[5] || out_ready;
   assign issue   = advance && head.valid;
   assign pop     = issue && (cnt_ff == cbt_pkg::IDX_W'(cbt_pkg::SEG_LAST));

   always_comb begin
      cnt_in = cnt_ff;
      if (issue) begin
         cnt_in = pop ? '0 : cnt_ff + 1'b1;
      end
      valid_in = valid_ff;
      if (advance) begin
         valid_in = {valid_ff[4:1], issue};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff   <= '0;
         valid_ff <= '0;
      end else begin
         cnt_ff   <= cnt_in;
         valid_ff <= valid_in;
      end
   end

   always_comb begin
      sh_x = cbt_pkg::SHIFTED_W'(s4_x_ff >>> cbt_pkg::PIX_SHIFT);
      sh_y = cbt_pkg::SHIFTED_W'(s4_y_ff >>> cbt_pkg::PIX_SHIFT);
      if (sh_x > PIX_MAX) begin
         s5_x_in = cbt_pkg::PIX_W'(PIX_MAX);
      end else if (sh_x < PIX_MIN) begin
         s5_x_in = cbt_pkg::PIX_W'(PIX_MIN);
      end else begin
         s5_x_in = cbt_pkg::PIX_W'(sh_x);
      end
      if (sh_y > PIX_MAX) begin
         s5_y_in = cbt_pkg::PIX_W'(PIX_MAX);
      end else if (sh_y < PIX_MIN) begin
         s5_y_in = cbt_pkg::PIX_W'(PIX_MIN);
      end else begin
         s5_y_in = cbt_pkg::PIX_W'(sh_y);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_w_ff     <= cbt_pkg::WEIGHT_TABLE[cnt_ff];
         s1_px_ff[0] <= head.curve.start_x;
         s1_px_ff[1] <= head.curve.pull_a_x;
         s1_px_ff[2] <= head.curve.pull_b_x;
         s1_px_ff[3] <= head.curve.end_x;
         s1_py_ff[0] <= head.curve.start_y;
         s1_py_ff[1] <= head.curve.pull_a_y;
         s1_py_ff[2] <= head.curve.pull_b_y;
         s1_py_ff[3] <= head.curve.end_y;
         idx_ff[1]   <= cnt_ff;
         last_ff[1]  <= (cnt_ff == cbt_pkg::IDX_W'(cbt_pkg::SEG_LAST));

         for (int k = 0; k < 4; k++) begin
            s2_tx_ff[k] <= $signed({1'b0, s1_w_ff[k]}) * s1_px_ff[k];
            s2_ty_ff[k] <= $signed({1'b0, s1_w_ff[k]}) * s1_py_ff[k];
         end

         s3_sx_ff <= cbt_pkg::SUM_W'(s2_tx_ff[0]) + cbt_pkg::SUM_W'(s2_tx_ff[1])
                   + cbt_pkg::SUM_W'(s2_tx_ff[2]) + cbt_pkg::SUM_W'(s2_tx_ff[3]);
         s3_sy_ff <= cbt_pkg::SUM_W'(s2_ty_ff[0]) + cbt_pkg::SUM_W'(s2_ty_ff[1])
                   + cbt_pkg::SUM_W'(s2_ty_ff[2]) + cbt_pkg::SUM_W'(s2_ty_ff[3]);

         s4_x_ff <= s3_sx_ff * $signed({1'b0, frame_width});
         s4_y_ff <= s3_sy_ff * $signed({1'b0, frame_height});

         s5_x_ff <= s5_x_in;
         s5_y_ff <= s5_y_in;

         for (int s = 2; s <= 5; s++) begin
            idx_ff[s]  <= idx_ff[s-1];
            last_ff[s] <= last_ff[s-1];
         end
      end
   end

   assign out_valid = valid_ff[5];
   assign out_x     = s5_x_ff;
   assign out_y     = s5_y_ff;
   assign out_index = cbt_pkg::VIDX_W'(idx_ff[5]);
   assign out_last  = last_ff[5];

   a_count_steps : assert property (@(posedge clock) disable iff (reset)
      (issue && !pop) |=> (cnt_ff == $past(cnt_ff) + 1'b1))
      else $error("vertex counter skipped a step");

   a_pop_restarts : assert property (@(posedge clock) disable iff (reset)
      pop |=> (cnt_ff == '0))
      else $error("vertex counter not cleared after the last vertex");

   a_stall_freezes : assert property (@(posedge clock) disable iff (reset)
      !advance |=> (valid_ff == $past(valid_ff) && cnt_ff == $past(cnt_ff)))
      else $error("pipeline moved during a stall");

endmodule
